FILE: sv/pfla_pkg.sv
// Shared types and constants of the paged free-list block allocator.
// Sizes, request/response payload structs and operation codes; no dependencies.
`default_nettype none

package pfla_pkg;

  localparam int unsigned MAX_PAGES           = 16;
  localparam int unsigned MAX_BLOCKS_PER_PAGE = 64;

  localparam int unsigned PAGE_W    = $clog2(MAX_PAGES);
  localparam int unsigned SLOT_W    = $clog2(MAX_BLOCKS_PER_PAGE);
  localparam int unsigned ADDR_W    = PAGE_W + SLOT_W;
  localparam int unsigned DEPTH     = MAX_PAGES * MAX_BLOCKS_PER_PAGE;
  localparam int unsigned LINK_W    = ADDR_W + 1;
  localparam int unsigned PAGES_W   = $clog2(MAX_PAGES + 1);
  localparam int unsigned NBLK_W    = $clog2(MAX_BLOCKS_PER_PAGE + 1);
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned BPP_W     = 7;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned OUT_PAGE_W = 4;
  localparam int unsigned OUT_SLOT_W = 6;

  localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [BPP_W-1:0]   BPP_RESET = BPP_W'(64);

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam logic        REG_BPP    = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [OUT_PAGE_W-1:0] page_index;
    logic [OUT_SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [OUT_PAGE_W-1:0] alloc_page;
    logic [OUT_SLOT_W-1:0] alloc_slot;
    logic [4:0]            pages_in_use;
    logic [COUNT_W-1:0]    total_blocks;
    logic [COUNT_W-1:0]    free_blocks;
  } rsp_t;

  function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] a,
                                                 logic [NBLK_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + (COUNT_W + 1)'(b);
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/pfla_if.sv
// Valid/ready channels of the allocator: request in, response out.
// Depends on pfla_pkg for the payload structs.
`default_nettype none

interface pfla_req_if;
  import pfla_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pfla_rsp_if;
  import pfla_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/pfla_link_ram.sv
// Link store of the free list: one write port, one read port, registered read.
// Depends on pfla_pkg for depth and link width.
`default_nettype none

module pfla_link_ram
  import pfla_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [LINK_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [LINK_W-1:0] rdata_o
);

  logic [LINK_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/paged_free_list_block_allocator_top.sv
// Paged free-list block allocator: request/response channels, APB config port.
// Depends on pfla_pkg, pfla_req_if/pfla_rsp_if and pfla_link_ram.
//
// Usage: each request on req_i is allocate, free or free-all; exactly one
// response follows on rsp_o, in request order. blocks_per_page sits at APB
// address 0 and may be written only while no request is in flight.
// Sequence per request:
//   free, free-all, failed allocate: response registered on accept.
//   allocate from a non-empty list: link read from the RAM, then head
//   update in ST_POP, which waits until the response slot can be filled.
//   allocate that claims a new page: ST_SWEEP writes one link per cycle into
//   the link RAM for the effective blocks_per_page, then ST_RD and ST_POP.
// One request is worked on at a time; the next is accepted once the output
// register is empty or its response is taken in the same cycle.
// Reset empties the list, clears all counters and sets blocks_per_page to 64;
// the link RAM is not cleared. A stalled receiver holds the response register,
// and the block takes no new request until the response slot can be filled.
`default_nettype none

module paged_free_list_block_allocator_top
  import pfla_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  pfla_req_if.sink                   req_i,
  pfla_rsp_if.source                 rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_RD    = 4'b0100,
    ST_POP   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [LINK_W-1:0]   head_q, head_d;
  logic [PAGES_W-1:0]  pages_q, pages_d;
  logic [COUNT_W-1:0]  blocks_q, blocks_d;
  logic [COUNT_W-1:0]  free_q, free_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [NBLK_W-1:0]   nblk_q, nblk_d;
  logic [BPP_W-1:0]    bpp_q;
  logic                out_valid_q, out_valid_d;
  rsp_t                rsp_q, rsp_d;

  logic                slot_avail;
  logic                req_fire;
  logic                out_load;
  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr, free_addr, base;
  logic [LINK_W-1:0]   wdata, rdata;
  logic [NBLK_W-1:0]   eff_bpp;
  logic [SLOT_W-1:0]   idx_inc;
  logic                sweep_last;
  logic                cfg_wr;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BPP);
  assign prdata = (paddr[2] == REG_BPP) ? {{(32 - BPP_W){1'b0}}, bpp_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BPP_RESET;
    end else if (cfg_wr) begin
      bpp_q <= pwdata[BPP_W-1:0];
    end
  end

  always_comb begin
    if (bpp_q == '0) begin
      eff_bpp = NBLK_W'(1);
    end else if ({{(32 - BPP_W){1'b0}}, bpp_q} > 32'(MAX_BLOCKS_PER_PAGE)) begin
      eff_bpp = NBLK_W'(MAX_BLOCKS_PER_PAGE);
    end else begin
      eff_bpp = NBLK_W'(bpp_q);
    end
  end

  pfla_link_ram u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign slot_avail  = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_avail;
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

  assign free_addr  = {req_i.data.page_index[PAGE_W-1:0], req_i.data.slot_index[SLOT_W-1:0]};
  assign base       = {pages_q[PAGE_W-1:0], {SLOT_W{1'b0}}};
  assign idx_inc    = idx_q + SLOT_W'(1);
  assign sweep_last = (NBLK_W'(idx_q) + NBLK_W'(1)) == nblk_q;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    pages_d  = pages_q;
    blocks_d = blocks_q;
    free_d   = free_q;
    idx_d    = idx_q;
    nblk_d   = nblk_q;
    rsp_d    = rsp_q;
    out_load = 1'b0;
    we       = 1'b0;
    waddr    = free_addr;
    wdata    = head_q;
    re       = 1'b0;
    raddr    = head_q[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          rsp_d.ok         = 1'b1;
          rsp_d.alloc_page = '0;
          rsp_d.alloc_slot = '0;
          case (req_i.data.kind)
            KIND_ALLOC: begin
              if (head_q != NULL_LINK) begin
                re      = 1'b1;
                state_d = ST_POP;
              end else if (pages_q < PAGES_W'(MAX_PAGES)) begin
                idx_d   = '0;
                nblk_d  = eff_bpp;
                state_d = ST_SWEEP;
              end else begin
                rsp_d.ok = 1'b0;
                out_load = 1'b1;
              end
            end
            KIND_FREE: begin
              we       = 1'b1;
              head_d   = {1'b0, free_addr};
              free_d   = sat_add(free_q, NBLK_W'(1));
              out_load = 1'b1;
            end
            KIND_CLEAR: begin
              head_d   = NULL_LINK;
              pages_d  = '0;
              blocks_d = '0;
              free_d   = '0;
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = {pages_q[PAGE_W-1:0], idx_q};
        wdata = sweep_last ? NULL_LINK : {1'b0, pages_q[PAGE_W-1:0], idx_inc};
        if (sweep_last) begin
          head_d   = {1'b0, base};
          pages_d  = pages_q + PAGES_W'(1);
          blocks_d = sat_add(blocks_q, nblk_q);
          free_d   = sat_add(free_q, nblk_q);
          state_d  = ST_RD;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_RD: begin
        re      = 1'b1;
        state_d = ST_POP;
      end
      ST_POP: begin
        if (slot_avail) begin
          head_d           = (rdata > NULL_LINK) ? NULL_LINK : rdata;
          free_d           = (free_q != '0) ? free_q - COUNT_W'(1) : free_q;
          rsp_d.ok         = 1'b1;
          rsp_d.alloc_page = OUT_PAGE_W'(head_q[ADDR_W-1:SLOT_W]);
          rsp_d.alloc_slot = OUT_SLOT_W'(head_q[SLOT_W-1:0]);
          out_load         = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      rsp_d.pages_in_use = 5'(pages_d);
      rsp_d.total_blocks = blocks_d;
      rsp_d.free_blocks  = free_d;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= NULL_LINK;
      pages_q     <= '0;
      blocks_q    <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      pages_q     <= pages_d;
      blocks_q    <= blocks_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    nblk_q <= nblk_d;
    rsp_q  <= rsp_d;
  end

endmodule

`default_nettype wire

FILE: sim/pfla_pool_checker.sv
`timescale 1ns / 100ps
// Watches the request, response and APB sides of the paged free-list allocator,
// keeps its own copy of the pool to predict each response, and counts mismatches.
// Depends on pfla_pkg and the pfla_req_if / pfla_rsp_if channel interfaces.

module pfla_pool_checker
  import pfla_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pfla_req_if                   req_mon,
  pfla_rsp_if                   rsp_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  pready,
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam logic [APB_ADDR_W-1:0] BPP_ADDR = {REG_BPP, 2'b00};

  logic [LINK_W-1:0]  link_mem [DEPTH];
  logic [LINK_W-1:0]  head;
  logic [PAGES_W-1:0] page_cnt;
  logic [COUNT_W-1:0] block_cnt;
  logic [COUNT_W-1:0] free_cnt;
  logic [BPP_W-1:0]   bpp;

  rsp_t expected_q [$];
  int   mismatch_cnt = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_cnt < 100) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
    mismatch_cnt++;
  endtask

  function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] a, int unsigned b);
    int unsigned s;
    s = int'(a) + b;
    return (s > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(s);
  endfunction

  function automatic void empty_pool();
    head      = NULL_LINK;
    page_cnt  = '0;
    block_cnt = '0;
    free_cnt  = '0;
  endfunction

  function automatic rsp_t step_pool(req_t r);
    rsp_t              outcome;
    int unsigned       n;
    int unsigned       base;
    logic [ADDR_W-1:0] blk;
    outcome    = '0;
    outcome.ok = 1'b1;
    case (r.kind)
      KIND_ALLOC: begin
        if (head == NULL_LINK && page_cnt < MAX_PAGES) begin
          if (bpp == 0) n = 1;
          else if (bpp > MAX_BLOCKS_PER_PAGE) n = MAX_BLOCKS_PER_PAGE;
          else n = bpp;
          base = page_cnt * MAX_BLOCKS_PER_PAGE;
          for (int unsigned i = 0; i < n; i++) begin
            link_mem[base + i] = (i + 1 < n) ? LINK_W'(base + i + 1) : NULL_LINK;
          end
          head      = LINK_W'(base);
          page_cnt  = page_cnt + 1'b1;
          block_cnt = bump(block_cnt, n);
          free_cnt  = bump(free_cnt, n);
        end
        if (head == NULL_LINK) begin
          outcome.ok = 1'b0;
        end else begin
          blk                = head[ADDR_W-1:0];
          outcome.alloc_page = blk[ADDR_W-1:SLOT_W];
          outcome.alloc_slot = blk[SLOT_W-1:0];
          head               = link_mem[blk];
          if (head > NULL_LINK) head = NULL_LINK;
          if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
        end
      end
      KIND_FREE: begin
        blk           = {r.page_index, r.slot_index};
        link_mem[blk] = head;
        head          = {1'b0, blk};
        free_cnt      = bump(free_cnt, 1);
      end
      KIND_CLEAR: begin
        empty_pool();
      end
      default: begin
      end
    endcase
    outcome.pages_in_use = page_cnt;
    outcome.total_blocks = block_cnt;
    outcome.free_blocks  = free_cnt;
    return outcome;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    rsp_t want;
    if (!rst_ni) begin
      empty_pool();
      bpp = BPP_RESET;
      expected_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected response", 32'(rsp_mon.data), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_mon.data.ok !== want.ok)
            report_mismatch("ok", 32'(rsp_mon.data.ok), 32'(want.ok));
          if (rsp_mon.data.alloc_page !== want.alloc_page)
            report_mismatch("alloc_page", 32'(rsp_mon.data.alloc_page), 32'(want.alloc_page));
          if (rsp_mon.data.alloc_slot !== want.alloc_slot)
            report_mismatch("alloc_slot", 32'(rsp_mon.data.alloc_slot), 32'(want.alloc_slot));
          if (rsp_mon.data.pages_in_use !== want.pages_in_use)
            report_mismatch("pages_in_use", 32'(rsp_mon.data.pages_in_use),
                            32'(want.pages_in_use));
          if (rsp_mon.data.total_blocks !== want.total_blocks)
            report_mismatch("total_blocks", 32'(rsp_mon.data.total_blocks),
                            32'(want.total_blocks));
          if (rsp_mon.data.free_blocks !== want.free_blocks)
            report_mismatch("free_blocks", 32'(rsp_mon.data.free_blocks),
                            32'(want.free_blocks));
        end
      end
      if (psel && penable && pready && paddr == BPP_ADDR) begin
        if (pwrite) begin
          bpp = pwdata[BPP_W-1:0];
        end else if (prdata !== 32'(bpp)) begin
          report_mismatch("blocks_per_page readback", prdata, 32'(bpp));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_q.push_back(step_pool(req_mon.data));
      end
    end
    mismatches_o = mismatch_cnt;
    pending_o    = expected_q.size();
  end

endmodule

FILE: sim/tb_paged_free_list_block_allocator_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the paged free-list allocator: directed cases, a burst of
// random frees followed by allocates, then random phases over several page sizes.
// Depends on pfla_pkg, the channel interfaces, pfla_pool_checker and the block.

module tb_paged_free_list_block_allocator_top;
  import pfla_pkg::*;

  localparam logic [KIND_W-1:0]     KIND_IGNORED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] BPP_ADDR     = {REG_BPP, 2'b00};
  localparam int unsigned           CYCLE_LIMIT  = 600_000;
  localparam int                    PHASE_ITEMS  = 140;
  localparam int                    NUM_PHASES   = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  pfla_req_if req_ch ();
  pfla_rsp_if rsp_ch ();

  int          mismatch_total;
  int          responses_owed;
  bit          stall_on      = 1'b0;
  bit          long_hold_req = 1'b0;
  int          hold_left     = 0;
  int unsigned cycle_count   = 0;

  paged_free_list_block_allocator_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pfla_pool_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mismatches_o (mismatch_total),
    .pending_o    (responses_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && long_hold_req) begin
        hold_left     = 300;
        long_hold_req = 1'b0;
      end else if (hold_left == 0 && stall_on && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 5);
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic req_t make_req(logic [KIND_W-1:0] k, logic [OUT_PAGE_W-1:0] pg,
                                    logic [OUT_SLOT_W-1:0] sl);
    req_t r;
    r.kind       = k;
    r.page_index = pg;
    r.slot_index = sl;
    return r;
  endfunction

  function automatic req_t random_req(int alloc_pct, int free_pct);
    int unsigned       pick;
    logic [KIND_W-1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) k = KIND_ALLOC;
    else if (pick < alloc_pct + free_pct) k = KIND_FREE;
    else if (pick < 97) k = KIND_CLEAR;
    else k = KIND_IGNORED;
    return make_req(k, OUT_PAGE_W'($urandom), OUT_SLOT_W'($urandom));
  endfunction

  task automatic send_request(req_t r);
    int gap;
    gap = (stall_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (responses_owed != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(bit is_write, logic [BPP_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= BPP_ADDR;
    pwdata  <= {25'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_blocks_per_page(logic [BPP_W-1:0] value);
    drain_responses();
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
  endtask

  initial begin
    logic [BPP_W-1:0] bpp_plan [NUM_PHASES];
    int               sent;
    int               seg;
    int               alloc_pct;
    int               free_pct;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b0, '0);
    stall_on = 1'b1;
    send_request(make_req(KIND_CLEAR, '0, '0));
    send_request(make_req(KIND_IGNORED, '1, '1));
    send_request(make_req(KIND_ALLOC, '1, '1));
    send_request(make_req(KIND_FREE, '1, '1));
    send_request(make_req(KIND_FREE, '1, '1));
    send_request(make_req(KIND_ALLOC, '0, '0));
    send_request(make_req(KIND_ALLOC, '0, '0));

    // one block per page: exhaust all frames, then one more allocate
    set_blocks_per_page('0);
    send_request(make_req(KIND_CLEAR, '0, '0));
    repeat (MAX_PAGES + 1) send_request(make_req(KIND_ALLOC, '0, '0));

    // push random handles onto the list, then pop past its end into new pages
    set_blocks_per_page('1);
    send_request(make_req(KIND_CLEAR, '0, '0));
    send_request(make_req(KIND_ALLOC, '0, '0));
    repeat (60) send_request(make_req(KIND_FREE, OUT_PAGE_W'($urandom),
                                      OUT_SLOT_W'($urandom)));
    repeat (140) send_request(make_req(KIND_ALLOC, OUT_PAGE_W'($urandom),
                                       OUT_SLOT_W'($urandom)));
    send_request(make_req(KIND_CLEAR, '0, '0));

    bpp_plan = '{7'd64, 7'd1, 7'd2, 7'd65, BPP_W'($urandom_range(1, 127)), 7'd127,
                 7'd0, 7'd64};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_blocks_per_page(bpp_plan[ph]);
      if (ph == 1) long_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        seg = $urandom_range(5, 40);
        if (seg > PHASE_ITEMS - sent) seg = PHASE_ITEMS - sent;
        stall_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: begin
            alloc_pct = 90;
            free_pct  = 5;
          end
          1: begin
            alloc_pct = 20;
            free_pct  = 75;
          end
          default: begin
            alloc_pct = 55;
            free_pct  = 35;
          end
        endcase
        repeat (seg) send_request(random_req(alloc_pct, free_pct));
        sent += seg;
      end
    end

    drain_responses();
    repeat (80) @(negedge clk_i);
    if (mismatch_total == 0 && responses_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
